/* hw/rtl/ttw_pkg.sv */
// Shared types, codes and helper functions of the translation table walker.
package ttw_pkg;

  localparam int PHYS_ADDR_BITS_DEF = 48;
  localparam int ADDR_W = 48;
  localparam int VA_W = 64;
  localparam int DESC_W = 64;
  localparam int IDX_W = 13;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DESC  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    KIND_READ       = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_FAULT      = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_GRANULE = 2'd0;
  localparam logic [1:0] CFG_LEVELS  = 2'd1;
  localparam logic [1:0] CFG_BASE    = 2'd2;

  localparam logic [1:0] GRAN_16K = 2'd1;
  localparam logic [1:0] GRAN_64K = 2'd2;

  localparam logic [1:0] DESC_TABLE = 2'b11;
  localparam logic [1:0] DESC_BLOCK = 2'b01;
  localparam logic [1:0] LAST_LEVEL = 2'd3;

  typedef struct packed {
    logic [1:0]        granule_select;
    logic [2:0]        level_count;
    logic [ADDR_W-1:0] table_base;
  } cfg_t;

  typedef struct packed {
    command_t          command;
    logic [VA_W-1:0]   virtual_address;
    logic [DESC_W-1:0] descriptor;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] entry_address;
    logic [1:0]        walk_level;
  } result_t;

  typedef struct packed {
    logic              active;
    logic [1:0]        level;
    logic [VA_W-1:0]   pending;
    logic [ADDR_W-1:0] location;
  } walk_state_t;

  // Table index of the virtual address at a level. Unused granule code means 4 KiB.
  function automatic logic [IDX_W-1:0] entry_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] gran,
                                                   input logic [1:0] lvl);
    logic [VA_W-1:0]  sh;
    logic [IDX_W-1:0] msk;
    unique case (gran)
      GRAN_16K: begin
        msk = 13'h07FF;
        unique case (lvl)
          2'd0: sh = va >> 47;
          2'd1: sh = va >> 36;
          2'd2: sh = va >> 25;
          2'd3: sh = va >> 14;
        endcase
      end
      GRAN_64K: begin
        msk = 13'h1FFF;
        unique case (lvl)
          2'd0: sh = va >> 55;
          2'd1: sh = va >> 42;
          2'd2: sh = va >> 29;
          2'd3: sh = va >> 16;
        endcase
      end
      default: begin
        msk = 13'h01FF;
        unique case (lvl)
          2'd0: sh = va >> 39;
          2'd1: sh = va >> 30;
          2'd2: sh = va >> 21;
          2'd3: sh = va >> 12;
        endcase
      end
    endcase
    return sh[IDX_W-1:0] & msk;
  endfunction

  // Bits below the page size, cleared from a next-level table address.
  function automatic logic [DESC_W-1:0] page_offset_mask(input logic [1:0] gran);
    logic [DESC_W-1:0] m;
    unique case (gran)
      GRAN_16K: m = 64'h3FFF;
      GRAN_64K: m = 64'hFFFF;
      default:  m = 64'h0FFF;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/ttw_if.sv */
// Channel interfaces of the translation table walker: item, result and configuration.
interface ttw_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] virtual_address;
  logic [63:0] descriptor;

  modport source (output valid, command, virtual_address, descriptor, input ready);
  modport sink (input valid, command, virtual_address, descriptor, output ready);
endinterface

interface ttw_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [47:0] entry_address;
  logic [1:0]  walk_level;

  modport source (output valid, result_kind, entry_address, walk_level, input ready);
  modport sink (input valid, result_kind, entry_address, walk_level, output ready);
endinterface

interface ttw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/translation_table_walker.sv */
// Top level of the translation table walker.
// One request per clock cycle is taken, back to back, while the result side is not stalled;
// each produces exactly one result, which appears on the result port from the result register:
// the input register is loaded at the accepting edge and the result register from it as the
// output advances, around the single step of walk logic. Configuration writes are taken in
// every cycle and belong in idle periods only. A start request answers with the read address
// of the first table entry; each descriptor request then returns the next read, done or fault.
module translation_table_walker import ttw_pkg::*; #(
  parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  ttw_cfg_if.sink       cfg,
  ttw_item_if.sink      item,
  ttw_result_if.source  result
);

  cfg_t        cfg_regs;
  item_t       item_reg;
  logic        item_valid;
  result_t     result_reg;
  logic        result_valid;
  walk_state_t walk;
  walk_state_t walk_next;
  result_t     step_result;
  logic        advance;
  logic        take;

  assign advance    = !result_valid || result.ready;
  assign item.ready = !item_valid || advance;
  assign take       = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_GRANULE: cfg_regs.granule_select <= cfg.data[1:0];
        CFG_LEVELS:  cfg_regs.level_count    <= cfg.data[2:0];
        CFG_BASE:    cfg_regs.table_base     <= cfg.data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (take) begin
      item_reg <= '{command: command_t'(item.command), virtual_address: item.virtual_address,
                    descriptor: item.descriptor};
    end
  end

  ttw_step #(.PHYS_ADDR_BITS(PHYS_ADDR_BITS)) u_step (
    .cfg        (cfg_regs),
    .item       (item_reg),
    .state      (walk),
    .result     (step_result),
    .state_next (walk_next)
  );

  // Walk state moves together with the result register, so the next request sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      walk         <= '0;
    end else if (advance) begin
      result_valid <= item_valid;
      if (item_valid) begin
        walk <= walk_next;
      end
    end
    if (advance && item_valid) begin
      result_reg <= step_result;
    end
  end

  assign result.valid         = result_valid;
  assign result.result_kind   = result_reg.kind;
  assign result.entry_address = result_reg.entry_address;
  assign result.walk_level    = result_reg.walk_level;

endmodule

/* hw/rtl/ttw_step.sv */
// One walk step: turns an item and the current walk state into a result and the next state.
module ttw_step import ttw_pkg::*; #(
  parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
  input  cfg_t        cfg,
  input  item_t       item,
  input  walk_state_t state,
  output result_t     result,
  output walk_state_t state_next
);

  localparam logic [63:0] PA_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;

  logic [2:0]        levels;
  logic [1:0]        start_level;
  logic [1:0]        step_level;
  logic [63:0]       base;
  logic [VA_W-1:0]   va_sel;
  logic [IDX_W-1:0]  idx;
  logic [63:0]       sum;
  logic [ADDR_W-1:0] entry;
  logic [1:0]        low_bits;
  logic              descend;

  assign levels      = (cfg.level_count > 3'd4) ? 3'd4 : cfg.level_count;
  assign start_level = 2'(3'd4 - levels);
  assign low_bits    = item.descriptor[1:0];
  assign descend     = (low_bits == DESC_TABLE) && (state.level != LAST_LEVEL);

  // One entry address unit serves both the first and the next-level lookup.
  always_comb begin
    if (item.command == CMD_START) begin
      base       = {16'd0, cfg.table_base} & PA_MASK;
      va_sel     = item.virtual_address;
      step_level = start_level;
    end else begin
      base       = item.descriptor & PA_MASK & ~page_offset_mask(cfg.granule_select);
      va_sel     = state.pending;
      step_level = 2'(state.level + 2'd1);
    end
    idx   = entry_index(va_sel, cfg.granule_select, step_level);
    sum   = (base + {48'd0, idx, 3'b000}) & PA_MASK;
    entry = sum[ADDR_W-1:0];
  end

  always_comb begin
    state_next = state;
    result     = '{kind: KIND_UNEXPECTED, entry_address: '0, walk_level: 2'd0};
    if (item.command == CMD_START) begin
      if (levels == 3'd0) begin
        state_next.active = 1'b0;
        result.kind       = KIND_FAULT;
      end else begin
        state_next = '{active: 1'b1, level: start_level, pending: item.virtual_address,
                       location: entry};
        result     = '{kind: KIND_READ, entry_address: entry, walk_level: start_level};
      end
    end else if (state.active) begin
      if (descend) begin
        state_next.level    = step_level;
        state_next.location = entry;
        result = '{kind: KIND_READ, entry_address: entry, walk_level: step_level};
      end else begin
        state_next.active    = 1'b0;
        result.entry_address = state.location;
        result.walk_level    = state.level;
        result.kind = (low_bits == DESC_TABLE || low_bits == DESC_BLOCK) ? KIND_DONE
                                                                         : KIND_FAULT;
      end
    end
  end

endmodule

/* hw/rtl/ttw_checker.sv */
// Port-level assertions for the translation table walker, bound to the top level.
module ttw_checker import ttw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  result_kind,
  input logic [47:0] entry_address,
  input logic [1:0]  walk_level
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(result_kind) && $stable(entry_address) && $stable(walk_level))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // With nothing waiting at the output, the input side is always open.
  assert property (@(posedge clk) disable iff (rst) !result_valid |-> item_ready)
    else $error("item not ready while output is empty");

  // A descriptor with no walk in progress names no entry.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_UNEXPECTED |->
      entry_address == 48'd0 && walk_level == 2'd0)
    else $error("unexpected descriptor result carries an entry");

  // An accepted request never disappears before a result is shown.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !result_valid |=> ##1 result_valid)
    else $error("accepted request produced no result");

endmodule

bind translation_table_walker ttw_checker u_ttw_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_kind   (result.result_kind),
  .entry_address (result.entry_address),
  .walk_level    (result.walk_level)
);

/* sim/ttw_walk_check.sv */
// Watches the walker's channels, predicts every answer and compares it with what comes out.
`timescale 1ns / 1ps

module ttw_walk_check import ttw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  ttw_cfg_if    cfg,
  ttw_item_if   item,
  ttw_result_if result,
  output int    mismatches,
  output int    outstanding,
  output int    answers_checked
);

  localparam int          PA_BITS = PHYS_ADDR_BITS_DEF;
  localparam logic [63:0] PA_MASK = (64'd1 << PA_BITS) - 64'd1;
  localparam int          REPORT_LIMIT = 10;

  // Shadow registers.
  logic [1:0]  granule;
  logic [2:0]  levels;
  logic [47:0] root_base;

  // Shadow walk.
  logic        walking;
  logic [1:0]  level;
  logic [63:0] walk_va;
  logic [47:0] entry_loc;

  result_t expected_answers[$];
  int      bad_count;
  int      seen_count;

  function automatic int unsigned page_bits(input logic [1:0] g);
    case (g)
      GRAN_16K: return 14;
      GRAN_64K: return 16;
      default:  return 12;
    endcase
  endfunction

  // Entry address at a level for the virtual address of the walk under way.
  function automatic logic [47:0] entry_of(input logic [63:0] tbl, input logic [1:0] lvl);
    int unsigned ps;
    int unsigned ib;
    int unsigned sh;
    logic [63:0] idx;
    logic [63:0] addr;
    ps   = page_bits(granule);
    ib   = ps - 3;
    sh   = ib * (3 - lvl) + ps;
    idx  = (walk_va >> sh) & ((64'd1 << ib) - 64'd1);
    addr = (tbl + idx * 64'd8) & PA_MASK;
    return addr[47:0];
  endfunction

  function automatic result_t walk_step(input command_t cmd, input logic [63:0] va,
                                        input logic [63:0] desc);
    result_t     r;
    logic [2:0]  eff;
    logic [63:0] next_base;
    r.kind          = KIND_UNEXPECTED;
    r.entry_address = '0;
    r.walk_level    = '0;
    if (cmd == CMD_START) begin
      eff = (levels > 3'd4) ? 3'd4 : levels;
      if (eff == 3'd0) begin
        walking = 1'b0;
        r.kind  = KIND_FAULT;
      end else begin
        walk_va         = va;
        level           = 2'(3'd4 - eff);
        entry_loc       = entry_of({16'b0, root_base}, level);
        walking         = 1'b1;
        r.kind          = KIND_READ;
        r.entry_address = entry_loc;
        r.walk_level    = level;
      end
    end else if (walking) begin
      if (desc[1:0] == DESC_TABLE && level != LAST_LEVEL) begin
        next_base       = desc & PA_MASK & ~((64'd1 << page_bits(granule)) - 64'd1);
        level           = level + 2'd1;
        entry_loc       = entry_of(next_base, level);
        r.kind          = KIND_READ;
      end else begin
        walking = 1'b0;
        if (desc[1:0] == DESC_TABLE || desc[1:0] == DESC_BLOCK) r.kind = KIND_DONE;
        else r.kind = KIND_FAULT;
      end
      r.entry_address = entry_loc;
      r.walk_level    = level;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      granule   = '0;
      levels    = '0;
      root_base = '0;
      walking   = 1'b0;
      level     = '0;
      walk_va   = '0;
      entry_loc = '0;
      bad_count  = 0;
      seen_count = 0;
      expected_answers.delete();
    end else begin
      // An answer can never belong to the request taken at the same edge.
      if (result.valid && result.ready) begin
        seen_count++;
        if (expected_answers.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("%0t: answer with none expected: kind %0d addr %h level %0d", $realtime,
                     result.result_kind, result.entry_address, result.walk_level);
        end else begin
          want = expected_answers.pop_front();
          if (result.result_kind !== want.kind || result.entry_address !== want.entry_address ||
              result.walk_level !== want.walk_level) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
              $display("%0t: expected kind %0d addr %h level %0d, got kind %0d addr %h level %0d",
                       $realtime, want.kind, want.entry_address, want.walk_level,
                       result.result_kind, result.entry_address, result.walk_level);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_GRANULE: granule   = cfg.data[1:0];
          CFG_LEVELS:  levels    = cfg.data[2:0];
          CFG_BASE:    root_base = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        expected_answers.push_back(walk_step(command_t'(item.command), item.virtual_address,
                                             item.descriptor));
    end
    mismatches      <= bad_count;
    outstanding     <= expected_answers.size();
    answers_checked <= seen_count;
  end

endmodule

/* sim/translation_table_walker_tb.sv */
// Stimulus and verdict for the translation table walker; checking lives in ttw_walk_check.
`timescale 1ns / 1ps

module translation_table_walker_tb;
  import ttw_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  ttw_cfg_if    cfg_ch ();
  ttw_item_if   item_ch ();
  ttw_result_if res_ch ();

  int mismatches;
  int outstanding;
  int answers_checked;

  translation_table_walker dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  ttw_walk_check walk_check (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_ch),
    .item            (item_ch),
    .result          (res_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .answers_checked (answers_checked)
  );

  int         idle_pct  = 0;
  int         stall_pct = 0;
  logic       hold_start;
  int         hold_left = 0;
  int         cycle_count = 0;
  int         starts_sent = 0;
  int         descs_sent = 0;
  int         settings_used = 0;
  logic [2:0] cur_levels = '0;

  // Result side: random stalls, plus a long hold-off when asked for.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d answers outstanding", cycle_count,
               outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Valid stays high on return; a drain, or an idle gap in the next call, lowers it.
  task automatic send_request(input command_t cmd, input logic [63:0] va,
                              input logic [63:0] desc);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.command         <= cmd;
    item_ch.virtual_address <= va;
    item_ch.descriptor      <= desc;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (cmd == CMD_START) starts_sent++;
    else descs_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] g, input logic [2:0] l, input logic [47:0] b);
    write_reg(CFG_GRANULE, {46'b0, g});
    write_reg(CFG_LEVELS, {45'b0, l});
    write_reg(CFG_BASE, b);
    cfg_ch.valid <= 1'b0;
    cur_levels = l;
    settings_used++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly complete walks with random content; the rest is stray requests.
  task automatic run_walks(input int count);
    int          first;
    int          pick;
    logic [2:0]  eff;
    logic [1:0]  lvl;
    logic [1:0]  low;
    logic        live;
    logic [63:0] d;
    first = starts_sent + descs_sent;
    eff   = (cur_levels > 3'd4) ? 3'd4 : cur_levels;
    while (starts_sent + descs_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_request(command_t'($urandom_range(1)), rand64(), rand64());
      end else begin
        send_request(CMD_START, rand64(), rand64());
        lvl  = 2'(3'd4 - eff);
        live = (eff != 3'd0);
        while (live) begin
          pick = $urandom_range(99);
          if (pick < 5) begin
            // Abandon the walk; the next start replaces it.
            live = 1'b0;
          end else begin
            if (pick < 75) low = DESC_TABLE;
            else if (pick < 88) low = DESC_BLOCK;
            else low = 2'($urandom_range(1)) << 1;
            d      = rand64();
            d[1:0] = low;
            send_request(CMD_DESC, rand64(), d);
            if (low == DESC_TABLE && lvl != LAST_LEVEL) lvl = lvl + 2'd1;
            else live = 1'b0;
          end
        end
      end
    end
  endtask

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] TOP_BASE = 48'hFFFF_FFFF_FFFF;

  logic [1:0] gran_plan [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0};
  logic [2:0] lvl_plan  [8] = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd7, 3'd4, 3'd0, 3'd5};

  initial begin
    logic [47:0] base;
    int          n;
    item_ch.valid           <= 1'b0;
    item_ch.command         <= CMD_START;
    item_ch.virtual_address <= '0;
    item_ch.descriptor      <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= CFG_GRANULE;
    cfg_ch.data             <= '0;
    hold_start              <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: no levels, so a start faults; a lone descriptor is unexpected.
    send_request(CMD_START, rand64(), rand64());
    send_request(CMD_DESC, rand64(), ALL_ONES);
    wait_drained();

    // Four levels from a table at address zero.
    configure(2'd0, 3'd4, 48'd0);
    send_request(CMD_START, 64'd0, 64'd0);
    send_request(CMD_DESC, 64'd0, 64'h1);
    send_request(CMD_START, ALL_ONES, 64'd0);
    send_request(CMD_DESC, 64'd0, ALL_ONES);
    send_request(CMD_DESC, 64'd0, ALL_ONES);
    send_request(CMD_DESC, 64'd0, ALL_ONES);
    send_request(CMD_DESC, 64'd0, ALL_ONES);
    send_request(CMD_START, 64'd0, 64'd0);
    send_request(CMD_DESC, 64'd0, 64'd0);
    send_request(CMD_START, ALL_ONES, 64'd0);
    send_request(CMD_DESC, 64'd0, 64'h3);
    send_request(CMD_DESC, 64'd0, 64'h2);
    // A start in the middle of a walk drops the old one.
    send_request(CMD_START, rand64(), 64'd0);
    send_request(CMD_START, rand64(), 64'd0);
    send_request(CMD_DESC, 64'd0, 64'h1);
    send_request(CMD_DESC, 64'd0, 64'h3);
    wait_drained();

    // Unused granule code and too many levels, with the highest base.
    configure(2'd3, 3'd7, TOP_BASE);
    send_request(CMD_START, ALL_ONES, 64'd0);
    send_request(CMD_DESC, 64'd0, ALL_ONES);
    send_request(CMD_DESC, 64'd0, ALL_ONES ^ 64'h2);
    wait_drained();

    configure(GRAN_64K, 3'd1, TOP_BASE);
    send_request(CMD_START, ALL_ONES, 64'd0);
    send_request(CMD_DESC, 64'd0, ALL_ONES);
    wait_drained();

    configure(GRAN_16K, 3'd2, 48'(rand64()));
    send_request(CMD_START, rand64(), 64'd0);
    send_request(CMD_DESC, 64'd0, rand64() | 64'h3);
    send_request(CMD_DESC, 64'd0, rand64() | 64'h3);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 2 || p == 7) base = TOP_BASE;
      else if (p == 3) base = '0;
      else base = 48'(rand64());
      configure(gran_plan[p], lvl_plan[p], base);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      n = (lvl_plan[p] == 3'd0) ? 120 : 245;
      if (p == 0) begin
        run_walks(60);
        // Hold the result side off while requests keep coming, so the input backs up.
        item_ch.valid <= 1'b0;
        hold_start    <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        run_walks(n - 60);
      end else if (p == 1) begin
        run_walks(n / 2);
        wait_drained();
        run_walks(n - n / 2);
      end else begin
        run_walks(n);
      end
      wait_drained();
    end

    $display("Covered %0d starts and %0d descriptor returns over %0d register settings.",
             starts_sent, descs_sent, settings_used);
    $display("Checked %0d answers under gaps, stalls and a %0d-cycle result hold-off.",
             answers_checked, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d answers missing", mismatches, outstanding);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
